/* rtl/tmr_pkg.sv */
// tmr_pkg: shared constants and controller/datapath interface types
// for the median tachometer; no dependencies
package tmr_pkg;

	localparam int WINDOW_DEF     = 9;
	localparam int COUNT_BITS_DEF = 16;
	localparam int IN_COUNT_W     = 16;
	localparam int SCALE_W        = 24;
	localparam int RPM_W          = 24;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd7500000;
	localparam logic [RPM_W-1:0]   RPM_MAX     = 24'hffffff;

	typedef struct packed {
		logic write;
		logic scan_en;
		logic div_start;
		logic div_en;
		logic out_load;
	} tmr_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic stall;
	} tmr_status_t;

endpackage

/* rtl/tacho_median_rpm_unit.sv */
// tacho_median_rpm_unit: top level of the median-of-window tachometer
// depends on tmr_pkg, tmr_ctrl and tmr_datapath
//
// Each transfer on the input writes one event (edge period or timeout) into
// a WINDOW-entry ring and yields exactly one result: rpm = rpm_scale / median
// period, 0xffffff for a zero median, or 0 with stalled set while the window
// holds a timeout or a full-scale count. The median is found by ranking one
// ring entry per cycle, and the quotient comes from a restoring divider that
// produces one bit per cycle; the divide is skipped when stalled. A new item
// is taken only once the last result is loaded into the output register,
// where it waits while the next item is taken. rpm_scale may be written in
// any cycle and resets to 7500000.
module tacho_median_rpm_unit import tmr_pkg::*; #(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [SCALE_W-1:0]    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [IN_COUNT_W-1:0] period_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RPM_W-1:0]      rpm,
	output logic                  stalled
);

	tmr_cmd_t    cmd;
	tmr_status_t status;

	tmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	tmr_datapath #(
		.WINDOW     (WINDOW),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.operation    (operation),
		.period_count (period_count),
		.cmd          (cmd),
		.status       (status),
		.rpm          (rpm),
		.stalled      (stalled)
	);

endmodule

/* rtl/tmr_datapath.sv */
// tmr_datapath: period ring, rank-based median select, serial divider,
// scale register and result register; depends on tmr_pkg
module tmr_datapath import tmr_pkg::*; #(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [SCALE_W-1:0]    cfg_wdata,
	input  logic                  operation,
	input  logic [IN_COUNT_W-1:0] period_count,
	input  tmr_cmd_t              cmd,
	output tmr_status_t           status,
	output logic [RPM_W-1:0]      rpm,
	output logic                  stalled
);

	localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int STEP_W  = $clog2(SCALE_W);
	localparam logic [CNT_W-1:0]      MED_RANK  = CNT_W'(WINDOW / 2);
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(WINDOW - 1);
	localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(SCALE_W - 1);
	localparam logic [COUNT_BITS-1:0] FULL      = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] ring_val_q [WINDOW];
	logic [WINDOW-1:0]     ring_to_q;
	logic [IDX_W-1:0]      slot_q;
	logic [IDX_W-1:0]      cand_q;
	logic [COUNT_BITS-1:0] med_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [SCALE_W-1:0]    div_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [STEP_W-1:0]     step_q;
	logic [RPM_W-1:0]      rpm_q;
	logic                  stalled_q;

	logic [COUNT_BITS-1:0] cnt_in;
	logic [COUNT_BITS-1:0] cand_val;
	logic [WINDOW-1:0]     lt_vec;
	logic [WINDOW-1:0]     le_vec;
	logic [WINDOW-1:0]     bad_vec;
	logic [CNT_W-1:0]      lt_cnt;
	logic [CNT_W-1:0]      le_cnt;
	logic                  is_median;
	logic [COUNT_BITS:0]   trial;
	logic                  q_bit;

	assign cnt_in   = COUNT_BITS'(period_count);
	assign cand_val = ring_val_q[cand_q];

	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			lt_vec[j]  = ring_val_q[j] < cand_val;
			le_vec[j]  = ring_val_q[j] <= cand_val;
			bad_vec[j] = ring_to_q[j] || (ring_val_q[j] == FULL);
		end
	end

	assign lt_cnt    = CNT_W'($countones(lt_vec));
	assign le_cnt    = CNT_W'($countones(le_vec));
	assign is_median = (lt_cnt <= MED_RANK) && (MED_RANK < le_cnt);

	// restoring divide step, one quotient bit per cycle
	assign trial = {rem_q, div_q[SCALE_W-1]};
	assign q_bit = trial >= {1'b0, med_q};

	assign status.scan_last = (cand_q == LAST_IDX);
	assign status.div_last  = (step_q == LAST_STEP);
	assign status.stall     = |bad_vec;

	// ring flags, write slot, scan and step counters, and scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_to_q <= '1;
			slot_q    <= '0;
			cand_q    <= '0;
			step_q    <= '0;
			scale_q   <= SCALE_RESET;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (cmd.write) begin
				ring_to_q[slot_q] <= operation;
				slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
				cand_q <= '0;
			end else if (cmd.scan_en) begin
				cand_q <= (cand_q == LAST_IDX) ? '0 : cand_q + 1'b1;
			end
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_en) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			ring_val_q[slot_q] <= operation ? '0 : cnt_in;
		end
		if (cmd.scan_en && is_median) begin
			med_q <= cand_val;
		end
		if (cmd.div_start) begin
			div_q <= scale_q;
			rem_q <= '0;
		end else if (cmd.div_en) begin
			div_q <= {div_q[SCALE_W-2:0], q_bit};
			rem_q <= q_bit ? COUNT_BITS'(trial - {1'b0, med_q}) : trial[COUNT_BITS-1:0];
		end
		if (cmd.out_load) begin
			stalled_q <= status.stall;
			if (status.stall) begin
				rpm_q <= '0;
			end else if (med_q == '0) begin
				rpm_q <= RPM_MAX;
			end else begin
				rpm_q <= div_q;
			end
		end
	end

	assign rpm     = rpm_q;
	assign stalled = stalled_q;

endmodule

/* rtl/tmr_ctrl.sv */
// tmr_ctrl: sequencer for write, median scan, divide and result transfer
// depends on tmr_pkg
module tmr_ctrl import tmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output tmr_cmd_t    cmd,
	input  tmr_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.write = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_en   = 1'b1;
				cmd.div_start = status.scan_last;
			end
			ST_DIVIDE: begin
				cmd.div_en = 1'b1;
			end
			ST_DELIVER: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DELIVER && cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= status.stall ? ST_DELIVER : ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (status.div_last) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SCAN)
		else $error("accepted transfer did not start a scan");

	a_result_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DELIVER)
		else $error("result raised outside deliver");

	a_divide_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> !status.stall)
		else $error("divider running on a stalled window");

	a_divide_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE && status.div_last |=> state_q == ST_DELIVER)
		else $error("divide did not end in deliver");

endmodule
